### rtl/cwr_pkg.sv
// cwr_pkg: shared types, codes and width helpers for the cumulative weight resampler
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package cwr_pkg;

  // fixed field widths of the ports
  localparam int CFG_W       = 11;
  localparam int IN_WEIGHT_W = 16;
  localparam int FRAC_W      = 16;
  localparam int OUT_IDX_W   = 10;
  localparam int CMD_KIND_W  = 2;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // reset value of the particle count register
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // input op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // kind of work handed from front to back
  typedef enum logic [CMD_KIND_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_FAIL   = 2'd2
  } cmd_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_CMP  = 2'd2,
    BK_DONE = 2'd3
  } back_state_e;

  // width helpers, evaluated at elaboration
  function automatic int idx_width(int max_p);
    return $clog2(max_p);
  endfunction

  function automatic int ptr_width(int max_p);
    return $clog2(max_p + 1);
  endfunction

  function automatic int weight_eff_width(int wb);
    return (wb < IN_WEIGHT_W) ? wb : IN_WEIGHT_W;
  endfunction

  function automatic int cum_width(int max_p, int wb);
    return weight_eff_width(wb) + ptr_width(max_p);
  endfunction

  function automatic int lhs_width(int max_p, int wb);
    return FRAC_W + cum_width(max_p, wb);
  endfunction

  function automatic int cmd_width(int max_p, int wb);
    return CMD_KIND_W + idx_width(max_p) + lhs_width(max_p, wb);
  endfunction

endpackage

### rtl/cumulative_weight_resampler.sv
// cumulative_weight_resampler: top level of the particle resampling engine
// instantiates cwr_front, cwr_queue and cwr_back; uses cwr_pkg
`timescale 1ns / 1ps

// Resampling engine for a particle filter. A load transaction (op 0) appends one
// weight to the current set. The back writes its cumulative sum to the table memory
// once the command reaches the head of the queue, and only after any running search
// has finished. The first load after any draw starts a new set. A draw transaction (op 1)
// returns the lowest index whose cumulative weight reaches random_fraction times the
// set total, found by a binary search over the table memory. Each search step is one
// registered memory read plus one compare. A draw before the set is fully loaded
// returns status 1 once the result register is free. A four-entry command queue sits
// between front and back, so loads keep being taken while a search runs, until the
// queue is full. particle_count may only be written while the block is idle; a value
// of zero acts as one.

module cumulative_weight_resampler #(
  parameter int MAX_PARTICLES = 1024,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [cwr_pkg::IN_WEIGHT_W-1:0] weight_i,
  input  logic [cwr_pkg::FRAC_W-1:0]      random_fraction_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cwr_pkg::OUT_IDX_W-1:0]   selected_index_o,
  output logic                           status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cwr_pkg::CFG_W-1:0]       particle_count_i
);
  import cwr_pkg::*;

  localparam int CMD_W = cmd_width(MAX_PARTICLES, WEIGHT_BITS);

  logic             q_push, q_full, q_pop, q_empty;
  logic [CMD_W-1:0] q_wdata, q_head;

  // front: classification and set bookkeeping
  cwr_front #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .weight_i         (weight_i),
    .random_fraction_i(random_fraction_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .particle_count_i (particle_count_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (q_wdata)
  );

  // command queue
  cwr_queue #(
    .W(CMD_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // back: table memory, search and result register
  cwr_back #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .selected_index_o(selected_index_o),
    .status_o        (status_o)
  );

endmodule

### rtl/cwr_front.sv
// cwr_front: accepts load and draw transactions, keeps the set bookkeeping
// and the count register, and pushes commands into the queue; uses cwr_pkg
`timescale 1ns / 1ps

module cwr_front #(
  parameter int MAX_PARTICLES = 1024,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     in_valid_i,
  output logic                                                     in_stall_o,
  input  logic                                                     op_i,
  input  logic [cwr_pkg::IN_WEIGHT_W-1:0]                          weight_i,
  input  logic [cwr_pkg::FRAC_W-1:0]                               random_fraction_i,
  input  logic                                                     cfg_valid_i,
  output logic                                                     cfg_ready_o,
  input  logic [cwr_pkg::CFG_W-1:0]                                particle_count_i,
  input  logic                                                     q_full_i,
  output logic                                                     q_push_o,
  output logic [cwr_pkg::cmd_width(MAX_PARTICLES, WEIGHT_BITS)-1:0] q_data_o
);
  import cwr_pkg::*;

  localparam int IDX_W     = idx_width(MAX_PARTICLES);
  localparam int PTR_W     = ptr_width(MAX_PARTICLES);
  localparam int WEFF_W    = weight_eff_width(WEIGHT_BITS);
  localparam int CUM_W     = cum_width(MAX_PARTICLES, WEIGHT_BITS);
  localparam int LHS_W     = lhs_width(MAX_PARTICLES, WEIGHT_BITS);
  localparam int CFG_EXT_W = (CFG_W > PTR_W) ? CFG_W : PTR_W;

  logic [CFG_W-1:0]     pcount_q;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [CUM_W-1:0]     total_q, total_d;
  logic                 phase_q, phase_d;

  logic [CFG_EXT_W-1:0] cfg_ext, count_ext;
  logic [PTR_W-1:0]     count;
  logic [IDX_W-1:0]     count_m1;
  logic [PTR_W-1:0]     ptr_base;
  logic [CUM_W-1:0]     total_base, total_new;
  logic                 load_ok, draw_ok, accept;
  logic [LHS_W-1:0]     lhs;
  cmd_e                 kind;
  logic [IDX_W-1:0]     addr;
  logic [LHS_W-1:0]     data;

  // config register: always ready; the user must write it only while idle, the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      pcount_q <= particle_count_i;
    end
  end

  // effective count, zero taken as one and clipped to the table depth
  always_comb begin
    cfg_ext = CFG_EXT_W'(pcount_q);
    if (cfg_ext == '0) begin
      count_ext = CFG_EXT_W'(1);
    end else if (cfg_ext > CFG_EXT_W'(MAX_PARTICLES)) begin
      count_ext = CFG_EXT_W'(MAX_PARTICLES);
    end else begin
      count_ext = cfg_ext;
    end
  end

  assign count    = PTR_W'(count_ext);
  assign count_m1 = IDX_W'(count - PTR_W'(1));

  // load path: a load after any draw opens a new set
  assign ptr_base   = phase_q ? '0 : ptr_q;
  assign total_base = phase_q ? '0 : total_q;
  assign total_new  = total_base + CUM_W'(weight_i[WEFF_W-1:0]);
  assign load_ok    = (ptr_base < count);

  // draw path: the set is complete once the pointer reaches the count
  assign draw_ok = (ptr_q >= count);
  assign lhs     = LHS_W'(random_fraction_i) * LHS_W'(total_q);

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // command build
  always_comb begin
    if (op_i == OP_DRAW) begin
      kind     = draw_ok ? CMD_SEARCH : CMD_FAIL;
      addr     = count_m1;
      data     = lhs;
      q_push_o = accept;
    end else begin
      kind     = CMD_WRITE;
      addr     = IDX_W'(ptr_base);
      data     = LHS_W'(total_new);
      q_push_o = accept && load_ok;
    end
  end

  assign q_data_o = {kind, addr, data};

  // set bookkeeping next state
  always_comb begin
    ptr_d   = ptr_q;
    total_d = total_q;
    phase_d = phase_q;
    if (accept) begin
      if (op_i == OP_DRAW) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (load_ok) begin
          ptr_d   = ptr_base + PTR_W'(1);
          total_d = total_new;
        end else begin
          ptr_d   = ptr_base;
          total_d = total_base;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      total_q <= '0;
      phase_q <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      total_q <= total_d;
      phase_q <= phase_d;
    end
  end

endmodule

### rtl/cwr_queue.sv
// cwr_queue: short command fifo that decouples the front from the back
// uses cwr_pkg for its depth and pointer widths
`timescale 1ns / 1ps

module cwr_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] head_o
);
  import cwr_pkg::*;

  logic [W-1:0]      slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/cwr_back.sv
// cwr_back: holds the cumulative weight memory, runs the binary search
// and drives the result register; uses cwr_pkg
`timescale 1ns / 1ps

module cwr_back #(
  parameter int MAX_PARTICLES = 1024,
  parameter int WEIGHT_BITS   = 16
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     q_empty_i,
  input  logic [cwr_pkg::cmd_width(MAX_PARTICLES, WEIGHT_BITS)-1:0] q_head_i,
  output logic                                                     q_pop_o,
  output logic                                                     out_valid_o,
  input  logic                                                     out_stall_i,
  output logic [cwr_pkg::OUT_IDX_W-1:0]                            selected_index_o,
  output logic                                                     status_o
);
  import cwr_pkg::*;

  localparam int IDX_W = idx_width(MAX_PARTICLES);
  localparam int CUM_W = cum_width(MAX_PARTICLES, WEIGHT_BITS);
  localparam int LHS_W = lhs_width(MAX_PARTICLES, WEIGHT_BITS);
  localparam int CMD_W = cmd_width(MAX_PARTICLES, WEIGHT_BITS);

  logic [CUM_W-1:0]     mem [MAX_PARTICLES];
  logic [CUM_W-1:0]     rdata_q;

  back_state_e          state_q, state_d;
  logic [IDX_W-1:0]     lo_q, hi_q, mid;
  logic [LHS_W-1:0]     lhs_q;

  logic                 out_valid_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic                 out_status_q;

  cmd_e                 head_kind;
  logic [IDX_W-1:0]     head_addr;
  logic [LHS_W-1:0]     head_data;
  logic                 slot_free, le;

  logic                 mem_we, start, out_load;
  logic [OUT_IDX_W-1:0] out_idx_d;
  logic                 out_status_d;

  // command fields
  assign head_kind = cmd_e'(q_head_i[CMD_W-1 -: CMD_KIND_W]);
  assign head_addr = q_head_i[LHS_W +: IDX_W];
  assign head_data = q_head_i[LHS_W-1:0];

  assign slot_free = !out_valid_q || !out_stall_i;
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign le        = (lhs_q <= {rdata_q, {FRAC_W{1'b0}}});

  // cumulative weight memory, registered read at the probe point
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[head_addr] <= head_data[CUM_W-1:0];
    end
    rdata_q <= mem[mid];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && head_kind == CMD_SEARCH) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        state_d = (lo_q == hi_q) ? BK_DONE : BK_CMP;
      end
      BK_CMP: begin
        state_d = BK_READ;
      end
      BK_DONE: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    start        = 1'b0;
    out_load     = 1'b0;
    out_idx_d    = OUT_IDX_W'(lo_q);
    out_status_d = STATUS_OK;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          case (head_kind)
            CMD_WRITE: begin
              mem_we  = 1'b1;
              q_pop_o = 1'b1;
            end
            CMD_SEARCH: begin
              start   = 1'b1;
              q_pop_o = 1'b1;
            end
            CMD_FAIL: begin
              if (slot_free) begin
                out_load     = 1'b1;
                out_idx_d    = '0;
                out_status_d = STATUS_SHORT;
                q_pop_o      = 1'b1;
              end
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_DONE: begin
        out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  // search bounds
  always_ff @(posedge clk_i) begin
    if (start) begin
      lo_q  <= '0;
      hi_q  <= head_addr;
      lhs_q <= head_data;
    end else if (state_q == BK_CMP) begin
      if (le) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid + IDX_W'(1);
      end
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q    <= out_idx_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_index_o = out_idx_q;
  assign status_o         = out_status_q;

endmodule
